### design/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sliding median filter
// Holds the controller states, the control group that the controller sends
// to the rank cells, and the fixed layout of the window size register.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int CFG_BITS = 4;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
		logic step;
	} ctl_t;

endpackage

### design/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter: one-dimensional median filter over signed samples
// A row of MAX_WINDOW rank cells holds the window; each result is ranked by
// passing every sample once around the ring of cells.
// ----------------------------------------------------------------------------
// For each result the ring is loaded, every cell then compares its sample
// against each travelling copy in MAX_WINDOW ring steps, and the median
// moves into the output register once that register is free. After the
// last sample of a stream the filter flushes the trailing positions one by
// one and ranks a result for each position that yields one. The window
// size register is read from the next sample on; zero acts as one, and
// values above MAX_WINDOW act as MAX_WINDOW.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
	parameter int MAX_WINDOW = 15,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [smf_pkg::CFG_BITS-1:0]       win_len,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               end_of_stream,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [SAMPLE_BITS-1:0]      median,
	output logic                               final_result
);

	localparam int IW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (IW > smf_pkg::CFG_BITS) ? IW : smf_pkg::CFG_BITS;

	smf_pkg::state_t state_q, state_nxt;
	smf_pkg::ctl_t   ctl;

	logic [smf_pkg::CFG_BITS-1:0] win_size_q;
	logic [CW-1:0]                raw_ext;
	logic [IW-1:0]                w_eff, w_half, delay;
	logic [IW-1:0]                seen_q, rem_q, rc_q;
	logic                         eos_q;
	logic                         emit_now;
	logic                         out_ld;
	logic                         last_emit;
	logic                         early_end;
	logic signed [SAMPLE_BITS-1:0] shift_val;
	logic signed [SAMPLE_BITS-1:0] sel_val;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic                          final_q;
	logic                          out_valid_q;

	logic signed [SAMPLE_BITS-1:0] win_a  [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] p_a    [MAX_WINDOW];
	logic        [IW-1:0]          pidx_a [MAX_WINDOW];
	logic        [IW-1:0]          rank_a [MAX_WINDOW];
	logic        [MAX_WINDOW-1:0]  match;

	assign raw_ext = CW'(win_size_q);
	always_comb begin
		if (win_size_q == '0) begin
			w_eff = IW'(1);
		end else if (raw_ext > CW'(MAX_WINDOW)) begin
			w_eff = IW'(MAX_WINDOW);
		end else begin
			w_eff = IW'(raw_ext);
		end
	end
	assign w_half = w_eff >> 1;
	assign delay  = w_eff - IW'(1) - w_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= smf_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			win_size_q <= win_len;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			localparam int LEFT = (gi == 0) ? MAX_WINDOW - 1 : gi - 1;
			logic signed [SAMPLE_BITS-1:0] left_win;

			if (gi == 0) begin : g_head
				assign left_win = shift_val;
			end else begin : g_body
				assign left_win = win_a[gi-1];
			end

			smf_cell #(
				.IDX(gi),
				.IW(IW),
				.SW(SAMPLE_BITS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.w_eff(w_eff),
				.left_win(left_win),
				.left_p(p_a[LEFT]),
				.left_pidx(pidx_a[LEFT]),
				.win(win_a[gi]),
				.p(p_a[gi]),
				.pidx(pidx_a[gi]),
				.rank(rank_a[gi])
			);

			assign match[gi] = (IW'(gi) < w_eff) && (rank_a[gi] == w_half);
		end
	endgenerate

	always_comb begin
		sel_val = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (match[i]) begin
				sel_val = sel_val | win_a[i];
			end
		end
	end

	assign emit_now  = (seen_q >= delay);
	assign out_ld    = (state_q == smf_pkg::ST_EMIT) && (!out_valid_q || !out_stall);
	assign last_emit = eos_q && (rem_q == '0);
	assign early_end = (state_q == smf_pkg::ST_FLUSH) && !emit_now && (rem_q == IW'(1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			smf_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (emit_now) begin
						state_nxt = smf_pkg::ST_RANK;
					end else if (end_of_stream) begin
						state_nxt = smf_pkg::ST_FLUSH;
					end
				end
			end
			smf_pkg::ST_RANK: begin
				if (rc_q == IW'(MAX_WINDOW)) begin
					state_nxt = smf_pkg::ST_EMIT;
				end
			end
			smf_pkg::ST_EMIT: begin
				if (out_ld) begin
					state_nxt = (eos_q && rem_q != '0) ?
						smf_pkg::ST_FLUSH : smf_pkg::ST_IDLE;
				end
			end
			smf_pkg::ST_FLUSH: begin
				if (emit_now) begin
					state_nxt = smf_pkg::ST_RANK;
				end else if (rem_q == IW'(1)) begin
					state_nxt = smf_pkg::ST_IDLE;
				end
			end
			default: state_nxt = smf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != smf_pkg::ST_IDLE);
		cfg_ready  = (state_q == smf_pkg::ST_IDLE);
		shift_val  = (state_q == smf_pkg::ST_FLUSH) ? '0 : sample;
		ctl.shift  = ((state_q == smf_pkg::ST_IDLE) && in_valid) ||
			(state_q == smf_pkg::ST_FLUSH);
		ctl.load   = (state_q == smf_pkg::ST_RANK) && (rc_q == '0);
		ctl.step   = (state_q == smf_pkg::ST_RANK) && (rc_q != '0);
		ctl.clear  = (out_ld && last_emit) || early_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smf_pkg::ST_IDLE;
			seen_q  <= '0;
			rem_q   <= '0;
			rc_q    <= '0;
			eos_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.clear) begin
				seen_q <= '0;
			end else if (ctl.shift) begin
				seen_q <= (seen_q == IW'(MAX_WINDOW)) ? seen_q : seen_q + 1'b1;
			end
			if (state_q == smf_pkg::ST_IDLE && in_valid) begin
				eos_q <= end_of_stream;
				rem_q <= delay;
			end else if (state_q == smf_pkg::ST_FLUSH) begin
				rem_q <= rem_q - 1'b1;
			end
			rc_q <= (state_q == smf_pkg::ST_RANK) ? rc_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			median_q <= sel_val;
			final_q  <= last_emit;
		end
	end

	assign out_valid    = out_valid_q;
	assign median       = median_q;
	assign final_result = final_q;

	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smf_pkg::ST_EMIT) |-> $onehot(match))
		else $error("median selection is not unique");

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= IW'(MAX_WINDOW))
		else $error("sample count out of range");

	a_flush_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smf_pkg::ST_FLUSH) |-> (rem_q != '0))
		else $error("flush step with no positions left");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && last_emit) |=> (seen_q == '0) && (state_q == smf_pkg::ST_IDLE))
		else $error("stream end did not clear the window");

endmodule

### design/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell: one rank cell of the median filter
// Holds one window sample, which shifts to the next cell when a sample
// enters. For ranking, a copy of every sample travels once around a ring of
// cells; each cell counts how many window samples order below its own.
// ----------------------------------------------------------------------------
module smf_cell #(
	parameter int IDX = 0,
	parameter int IW = 4,
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smf_pkg::ctl_t        ctl,
	input  logic        [IW-1:0] w_eff,
	input  logic signed [SW-1:0] left_win,
	input  logic signed [SW-1:0] left_p,
	input  logic        [IW-1:0] left_pidx,
	output logic signed [SW-1:0] win,
	output logic signed [SW-1:0] p,
	output logic        [IW-1:0] pidx,
	output logic        [IW-1:0] rank
);

	logic signed [SW-1:0] win_q;
	logic signed [SW-1:0] p_q;
	logic        [IW-1:0] pidx_q;
	logic        [IW-1:0] cnt_q;
	logic                 below;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= left_win;
		end
	end

	assign below = (pidx_q < w_eff) &&
		((p_q < win_q) || ((p_q == win_q) && (pidx_q < IW'(IDX))));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			p_q    <= win_q;
			pidx_q <= IW'(IDX);
			cnt_q  <= '0;
		end else if (ctl.step) begin
			p_q    <= left_p;
			pidx_q <= left_pidx;
			if (below) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign win  = win_q;
	assign p    = p_q;
	assign pidx = pidx_q;
	assign rank = cnt_q;

endmodule

### verif/sliding_median_filter_checker.sv
// ----------------------------------------------------------------------------
// sliding_median_filter_checker: result predictor and scoreboard
// Watches the window size writes and the sample and median transfers of the
// filter. It keeps its own copy of the sample history and the window size,
// works out the medians each accepted sample should produce, and compares
// every median transfer in order against them.
// ----------------------------------------------------------------------------
module sliding_median_filter_checker #(
	parameter int MAX_WINDOW = 15,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [smf_pkg::CFG_BITS-1:0]       win_len,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               end_of_stream,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [SAMPLE_BITS-1:0]      median,
	input  logic                               final_result,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct {
		sample_t value;
		logic    last;
	} median_t;

	median_t pending_medians[$];
	sample_t history[MAX_WINDOW];
	int unsigned taken;
	logic [smf_pkg::CFG_BITS-1:0] width_reg;

	function automatic int unsigned active_width();
		int unsigned w;
		w = width_reg;
		if (w == 0)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		return w;
	endfunction

	function automatic sample_t window_rank(input int unsigned w);
		sample_t sorted[MAX_WINDOW];
		sample_t key;
		int j;
		for (int i = 0; i < MAX_WINDOW; i++)
			sorted[i] = history[i];
		for (int i = 1; i < w; i++) begin
			key = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		return sorted[w/2];
	endfunction

	task automatic shift_history(input sample_t v);
		for (int i = MAX_WINDOW - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = v;
	endtask

	task automatic clear_history();
		for (int i = 0; i < MAX_WINDOW; i++)
			history[i] = '0;
		taken = 0;
	endtask

	task automatic predict_medians(input sample_t v, input logic eos);
		int unsigned w;
		int unsigned delay;
		int unsigned seen;
		int unsigned n;
		median_t m;
		w = active_width();
		delay = w - 1 - w/2;
		seen = taken;
		n = 0;
		m.last = 1'b0;
		shift_history(v);
		if (seen >= delay) begin
			m.value = window_rank(w);
			pending_medians = {pending_medians, m};
			n++;
		end
		taken = (seen + 1 > MAX_WINDOW) ? MAX_WINDOW : seen + 1;
		if (eos) begin
			// Flush the trailing positions with zero padding.
			for (int unsigned k = 1; k <= delay; k++) begin
				shift_history('0);
				if (seen + k >= delay) begin
					m.value = window_rank(w);
					pending_medians = {pending_medians, m};
					n++;
				end
			end
			if (n > 0) begin
				m = pending_medians[pending_medians.size() - 1];
				m.last = 1'b1;
				pending_medians[pending_medians.size() - 1] = m;
			end
			clear_history();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		median_t want;
		if (!arst_n) begin
			clear_history();
			width_reg = smf_pkg::CFG_RESET;
			pending_medians.delete();
			mismatches = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (pending_medians.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected median transfer %0d final %0b",
						$time, median, final_result);
				end else begin
					want = pending_medians.pop_front();
					if (median !== want.value) begin
						mismatches++;
						$display("%0t: median expected %0d actual %0d",
							$time, want.value, median);
					end
					if (final_result !== want.last) begin
						mismatches++;
						$display("%0t: final_result expected %0b actual %0b",
							$time, want.last, final_result);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_medians(sample, end_of_stream);
			if (cfg_valid && cfg_ready)
				width_reg = win_len;
			outstanding <= pending_medians.size();
		end
	end

endmodule

### verif/sliding_median_filter_test.sv
// ----------------------------------------------------------------------------
// sliding_median_filter_test: top level testbench of the median filter
// Drives sample streams and window size writes into the filter, with random
// gaps on the sample side and random stalls on the median side. A directed
// part covers extreme samples, one-sample streams, the largest, zero and
// even window sizes and a window change in the middle of a stream;
// random streams follow. The checker beside the filter scores the medians.
// ----------------------------------------------------------------------------
module sliding_median_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WINDOW = 15;
	localparam int SAMPLE_BITS = 16;
	localparam int STALL_PCT = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_SAMPLES = 190;
	localparam logic [smf_pkg::CFG_BITS-1:0] WIDTH_ZERO = 4'd0;
	localparam logic [smf_pkg::CFG_BITS-1:0] WIDTH_MIN = 4'd1;
	localparam logic [smf_pkg::CFG_BITS-1:0] WIDTH_EVEN = 4'd2;
	localparam logic [smf_pkg::CFG_BITS-1:0] WIDTH_MAX = 4'd15;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [smf_pkg::CFG_BITS-1:0] width_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [smf_pkg::CFG_BITS-1:0]  win_len;
	logic                          in_valid;
	logic                          in_stall;
	sample_t                       sample;
	logic                          end_of_stream;
	logic                          out_valid;
	logic                          out_stall;
	sample_t                       median;
	logic                          final_result;

	int mismatches;
	int outstanding;
	int checked;
	int quiet_cycles;
	int samples_sent;
	int streams_sent;
	int width_writes;
	logic idling;

	sliding_median_filter #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.win_len(win_len),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median(median),
		.final_result(final_result)
	);

	sliding_median_filter_checker #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.win_len(win_len),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median(median),
		.final_result(final_result),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.checked(checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= idling && ($urandom_range(0, 99) < STALL_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_sample(input sample_t v, input logic eos);
		while (idling && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		end_of_stream <= eos;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		if (eos)
			streams_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [smf_pkg::CFG_BITS-1:0] w);
		cfg_valid <= 1'b1;
		win_len <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		width_writes++;
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(16'sh7FFF);
			1: return sample_t'(16'sh8000);
			2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
			default: return sample_t'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic send_stream(input int len, input logic closed);
		for (int i = 1; i <= len; i++)
			send_sample(random_sample(), closed && (i == len));
	endtask

	initial begin
		sample_t corners[9];
		logic [smf_pkg::CFG_BITS-1:0] w;
		int streams;
		int len;
		int target;
		corners = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000,
			16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		win_len = smf_pkg::CFG_RESET;
		in_valid = 1'b0;
		sample = '0;
		end_of_stream = 1'b0;
		out_stall = 1'b0;
		quiet_cycles = 0;
		samples_sent = 0;
		streams_sent = 0;
		width_writes = 0;
		idling = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window size straight out of reset, extreme and alternating samples.
		for (int i = 0; i < 9; i++)
			send_sample(corners[i], i == 8);
		send_sample(16'sh8000, 1'b1);
		wait_drained();
		write_width(WIDTH_MAX);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0003, 1'b0);
		send_sample(16'shFFFD, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
		wait_drained();
		write_width(WIDTH_ZERO);
		send_sample(16'sh1234, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);
		wait_drained();
		write_width(4'd4);
		send_sample(16'sh0100, 1'b0);
		send_sample(16'shFF00, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		// The window grows while the stream is still open.
		wait_drained();
		write_width(4'd9);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh4000, 1'b0);
		send_sample(16'shC000, 1'b1);

		target = samples_sent + RANDOM_SAMPLES;
		while (samples_sent < target) begin
			idling = !(samples_sent >= target - 150 && samples_sent < target - 90);
			wait_drained();
			case ($urandom_range(0, 6))
				0: w = WIDTH_ZERO;
				1: w = WIDTH_MIN;
				2: w = WIDTH_MAX;
				3: w = WIDTH_EVEN;
				default: w = width_t'($urandom_range(0, MAX_WINDOW));
			endcase
			write_width(w);
			streams = $urandom_range(1, 4);
			for (int s = 1; s <= streams; s++) begin
				len = ($urandom_range(0, 4) == 0) ?
					$urandom_range(13, 30) : $urandom_range(1, 12);
				send_stream(len, !(s == streams && $urandom_range(0, 3) == 0));
			end
		end
		send_sample(random_sample(), 1'b1);
		idling = 1'b1;
		wait_drained();

		$display("Sent %0d samples in %0d closed streams over %0d window size writes;",
			samples_sent, streams_sent, width_writes);
		$display("%0d medians checked.", checked);
		if (outstanding != 0)
			$display("%0d expected medians never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
